### design/hrr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrr_pkg: shared types and constants of the maintenance report parser
// Item and result structs, parser phases, error codes, header and record
// code tables, hex digit decode.
// ----------------------------------------------------------------------------
package hrr_pkg;

    localparam int MAX_LINE_BYTES_DEF = 10;
    localparam int MAX_LINE_CHARS_DEF = 50;

    localparam int HDR_LEN    = 23;
    localparam int PRE_LEN    = 6;
    localparam int KEPT_BYTES = 7;
    localparam int N_CODES    = 15;

    localparam logic [31:0] TAG_RESET = 32'h0104_0000;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    localparam logic [7:0] HDR_TEXT [HDR_LEN] = '{
        8'h40, 8'h50, 8'h4A, 8'h4C, 8'h20, 8'h49, 8'h4E, 8'h46, 8'h4F, 8'h20,
        8'h42, 8'h52, 8'h4D, 8'h41, 8'h49, 8'h4E, 8'h54, 8'h45, 8'h4E, 8'h41,
        8'h4E, 8'h43, 8'h45
    };

    localparam logic [7:0] PRE_TEXT [PRE_LEN] = '{
        8'h44, 8'h41, 8'h54, 8'h41, 8'h3D, 8'h22
    };

    localparam logic [7:0] CODE_TAB [N_CODES] = '{
        8'h69, 8'h6A, 8'h6D, 8'h6F, 8'h70, 8'h71, 8'h72, 8'h73,
        8'h74, 8'h75, 8'h7E, 8'h79, 8'h7A, 8'h7B, 8'h80
    };

    localparam logic PCT_TAB [N_CODES] = '{
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1
    };

    typedef enum logic [5:0] {
        PH_HDR  = 6'b000001,
        PH_GAP  = 6'b000010,
        PH_PRE  = 6'b000100,
        PH_BODY = 6'b001000,
        PH_SKIP = 6'b010000,
        PH_HALT = 6'b100000
    } phase_t;

    typedef enum logic [2:0] {
        ERR_HEADER     = 3'd0,
        ERR_LINE_START = 3'd1,
        ERR_HEX_DIGIT  = 3'd2,
        ERR_MANY_BYTES = 3'd3,
        ERR_MANY_DIGIT = 3'd4
    } err_code_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } item_t;

    typedef struct packed {
        logic        is_error;
        logic [3:0]  slot;
        logic [15:0] reading;
        logic        is_percent;
        logic [2:0]  error_code;
    } result_t;

    // {bad, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] d;
        logic [7:0] u;
        logic [7:0] l;
        d = c - 8'h30;
        u = c - 8'h37;
        l = c - 8'h57;
        if (c >= 8'h30 && c <= 8'h39) begin
            hex_decode = {1'b0, d[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            hex_decode = {1'b0, u[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            hex_decode = {1'b0, l[3:0]};
        end else begin
            hex_decode = 5'b1_0000;
        end
    endfunction

endpackage
`default_nettype wire

### design/hrr_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrr_in_reg: input register
// Holds one accepted item until the parser core takes it.
// ----------------------------------------------------------------------------
module hrr_in_reg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire hrr_pkg::item_t s_item,
    input  wire logic          take,
    output logic               item_valid,
    output hrr_pkg::item_t     item
);

    logic           valid_reg;
    logic           valid_next;
    hrr_pkg::item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule
`default_nettype wire

### design/hrr_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrr_core: parser state and per-character decode
// Updates line state, up to one item per cycle; produces an error or record.
// ----------------------------------------------------------------------------
module hrr_core #(
    parameter int MAX_LINE_BYTES = hrr_pkg::MAX_LINE_BYTES_DEF,
    parameter int MAX_LINE_CHARS = hrr_pkg::MAX_LINE_CHARS_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [31:0]    cfg_expected_tag,
    input  wire logic           item_valid,
    input  wire hrr_pkg::item_t item,
    input  wire logic           out_space,
    output logic                take,
    output logic                fire,
    output hrr_pkg::result_t    result
);

    localparam int LC_W = $clog2(MAX_LINE_CHARS);
    localparam int BC_W = $clog2(MAX_LINE_BYTES + 1);
    localparam int KB   = hrr_pkg::KEPT_BYTES;

    logic [31:0]     tag_reg;
    hrr_pkg::phase_t phase_reg,  phase_next;
    logic [4:0]      match_reg,  match_next;
    logic [LC_W-1:0] lc_reg,     lc_next;
    logic [BC_W-1:0] bc_reg,     bc_next;
    logic [7:0]      lb_reg [KB];
    logic [7:0]      lb_next [KB];
    logic [7:0]      dp_reg,     dp_next;
    logic [1:0]      dc_reg,     dc_next;
    logic            db_reg,     db_next;

    logic            eol;
    logic            sep;
    logic [4:0]      hex;
    logic            err_hit;
    hrr_pkg::err_code_t err_code;
    logic            rec_chk;
    logic            code_hit;
    logic [3:0]      code_slot;
    logic            code_pct;
    logic            rec_ok;

    assign cfg_ready = 1'b1;
    assign take      = item_valid && out_space;
    assign eol       = (item.ch == hrr_pkg::CH_CR) || (item.ch == hrr_pkg::CH_LF);
    assign sep       = (item.ch == hrr_pkg::CH_COMMA) || (item.ch == hrr_pkg::CH_QUOTE);
    assign hex       = hrr_pkg::hex_decode(item.ch);

    always_comb begin
        phase_next = phase_reg;
        match_next = match_reg;
        lc_next    = lc_reg;
        bc_next    = bc_reg;
        lb_next    = lb_reg;
        dp_next    = dp_reg;
        dc_next    = dc_reg;
        db_next    = db_reg;
        err_hit    = 1'b0;
        err_code   = hrr_pkg::ERR_HEADER;
        rec_chk    = 1'b0;
        case (phase_reg)
            hrr_pkg::PH_HDR: begin
                if (eol) begin
                    if (match_reg == 5'(hrr_pkg::HDR_LEN)) begin
                        phase_next = hrr_pkg::PH_GAP;
                    end else if (match_reg != 5'd0) begin
                        err_hit  = 1'b1;
                        err_code = hrr_pkg::ERR_HEADER;
                    end
                end else if (match_reg < 5'(hrr_pkg::HDR_LEN)
                             && item.ch == hrr_pkg::HDR_TEXT[match_reg]) begin
                    match_next = match_reg + 5'd1;
                end else begin
                    err_hit  = 1'b1;
                    err_code = hrr_pkg::ERR_HEADER;
                end
            end
            hrr_pkg::PH_GAP: begin
                if (!eol) begin
                    lc_next = '0;
                    bc_next = '0;
                    dp_next = '0;
                    dc_next = '0;
                    db_next = 1'b0;
                    if (item.ch == hrr_pkg::CH_FF) begin
                        phase_next = hrr_pkg::PH_SKIP;
                    end else if (item.ch == hrr_pkg::PRE_TEXT[0]) begin
                        lc_next    = LC_W'(1);
                        phase_next = hrr_pkg::PH_PRE;
                    end else begin
                        err_hit  = 1'b1;
                        err_code = hrr_pkg::ERR_LINE_START;
                    end
                end
            end
            hrr_pkg::PH_PRE: begin
                if (eol || lc_reg >= LC_W'(hrr_pkg::PRE_LEN)
                    || item.ch != hrr_pkg::PRE_TEXT[lc_reg[2:0]]) begin
                    err_hit  = 1'b1;
                    err_code = hrr_pkg::ERR_LINE_START;
                end else begin
                    lc_next = lc_reg + LC_W'(1);
                    if (lc_reg == LC_W'(hrr_pkg::PRE_LEN - 1)) begin
                        phase_next = hrr_pkg::PH_BODY;
                    end
                end
            end
            hrr_pkg::PH_BODY: begin
                if (eol) begin
                    rec_chk    = 1'b1;
                    phase_next = hrr_pkg::PH_GAP;
                end else if (lc_reg < LC_W'(MAX_LINE_CHARS - 1)) begin
                    lc_next = lc_reg + LC_W'(1);
                    if (sep) begin
                        if (bc_reg >= BC_W'(MAX_LINE_BYTES)) begin
                            err_hit  = 1'b1;
                            err_code = hrr_pkg::ERR_MANY_BYTES;
                        end else if (db_reg) begin
                            err_hit  = 1'b1;
                            err_code = hrr_pkg::ERR_HEX_DIGIT;
                        end else begin
                            for (int k = 0; k < KB; k++) begin
                                if (bc_reg == BC_W'(k)) begin
                                    lb_next[k] = dp_reg;
                                end
                            end
                            bc_next = bc_reg + BC_W'(1);
                            dc_next = 2'd0;
                        end
                    end else if (dc_reg < 2'd2) begin
                        if (dc_reg == 2'd0) begin
                            dp_next = {hex[3:0], dp_reg[3:0]};
                        end else begin
                            dp_next = {dp_reg[7:4], hex[3:0]};
                        end
                        db_next = db_reg | hex[4];
                        dc_next = dc_reg + 2'd1;
                    end else begin
                        err_hit  = 1'b1;
                        err_code = hrr_pkg::ERR_MANY_DIGIT;
                    end
                end
            end
            hrr_pkg::PH_SKIP: begin
                if (eol) begin
                    phase_next = hrr_pkg::PH_GAP;
                end
            end
            hrr_pkg::PH_HALT: begin
                phase_next = hrr_pkg::PH_HALT;
            end
            default: begin
                phase_next = hrr_pkg::PH_HDR;
            end
        endcase
        if (err_hit) begin
            phase_next = hrr_pkg::PH_HALT;
        end
        if (item.last) begin
            if (!err_hit) begin
                if (phase_next == hrr_pkg::PH_HDR
                    && match_next != 5'(hrr_pkg::HDR_LEN)) begin
                    err_hit  = 1'b1;
                    err_code = hrr_pkg::ERR_HEADER;
                end else if (phase_next == hrr_pkg::PH_PRE) begin
                    err_hit  = 1'b1;
                    err_code = hrr_pkg::ERR_LINE_START;
                end else if (phase_next == hrr_pkg::PH_BODY) begin
                    rec_chk = 1'b1;
                end
            end
            phase_next = hrr_pkg::PH_HDR;
            match_next = 5'd0;
        end
    end

    always_comb begin
        code_hit  = 1'b0;
        code_slot = 4'd0;
        code_pct  = 1'b0;
        for (int k = 0; k < hrr_pkg::N_CODES; k++) begin
            if (lb_next[0] == hrr_pkg::CODE_TAB[k]) begin
                code_hit  = 1'b1;
                code_slot = 4'(k);
                code_pct  = hrr_pkg::PCT_TAB[k];
            end
        end
    end

    assign rec_ok = rec_chk && bc_next == BC_W'(KB) && code_hit
                    && {lb_next[1], lb_next[2], lb_next[3], lb_next[4]} == tag_reg;
    assign fire   = err_hit || rec_ok;

    always_comb begin
        result = '0;
        if (err_hit) begin
            result.is_error   = 1'b1;
            result.error_code = err_code;
        end else begin
            result.slot       = code_slot;
            result.reading    = {lb_next[5], lb_next[6]};
            result.is_percent = code_pct;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg   <= hrr_pkg::TAG_RESET;
            phase_reg <= hrr_pkg::PH_HDR;
            match_reg <= '0;
            lc_reg    <= '0;
            bc_reg    <= '0;
            dp_reg    <= '0;
            dc_reg    <= '0;
            db_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                tag_reg <= cfg_expected_tag;
            end
            if (take) begin
                phase_reg <= phase_next;
                match_reg <= match_next;
                lc_reg    <= lc_next;
                bc_reg    <= bc_next;
                dp_reg    <= dp_next;
                dc_reg    <= dc_next;
                db_reg    <= db_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            lb_reg <= lb_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_last_rearms: assert property (@(posedge aclk) disable iff (!aresetn)
        take && item.last |=> phase_reg == hrr_pkg::PH_HDR && match_reg == 5'd0)
        else $error("parser did not rearm after last item");

    a_error_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        take && err_hit && !item.last |=> phase_reg == hrr_pkg::PH_HALT)
        else $error("parser did not halt after error");

    a_byte_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bc_reg <= BC_W'(MAX_LINE_BYTES) && lc_reg <= LC_W'(MAX_LINE_CHARS - 1))
        else $error("line counters out of range");

    a_record_line: assert property (@(posedge aclk) disable iff (!aresetn)
        take && rec_ok |-> !err_hit && bc_next == BC_W'(KB) && result.slot <= 4'd14)
        else $error("record from malformed line");
`endif

endmodule
`default_nettype wire

### design/hrr_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrr_out_reg: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module hrr_out_reg (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             load,
    input  wire logic             fire,
    input  wire hrr_pkg::result_t result,
    output logic                  out_space,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output hrr_pkg::result_t      m_result
);

    logic             valid_reg;
    logic             valid_next;
    hrr_pkg::result_t result_reg;

    assign out_space = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_result  = result_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = fire;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && fire) begin
            result_reg <= result;
        end
    end

endmodule
`default_nettype wire

### design/hex_record_report_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hex_record_report_parser: maintenance report parser
// Checks the header line, decodes DATA=" lines of hex pairs and reports
// matching seven-byte records or the first error of a message.
//
//   channel  direction  ports
//   s_       in         s_valid s_ready s_ch s_last
//   m_       out        m_valid m_ready m_is_error m_slot m_reading
//                       m_is_percent m_error_code
//   cfg_     in         cfg_valid cfg_ready cfg_expected_tag
//
// One item per cycle while the result register has space; an item
// passes the input register and one parser core pass into the result register.
// Reset clears the parser to wait for a header and loads the default tag.
// A full result register stalls the core, which then holds the input register.
// ----------------------------------------------------------------------------
module hex_record_report_parser #(
    parameter int MAX_LINE_BYTES = hrr_pkg::MAX_LINE_BYTES_DEF,
    parameter int MAX_LINE_CHARS = hrr_pkg::MAX_LINE_CHARS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_ch,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_is_error,
    output logic [3:0]       m_slot,
    output logic [15:0]      m_reading,
    output logic             m_is_percent,
    output logic [2:0]       m_error_code,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_expected_tag
);

    hrr_pkg::item_t   s_item;
    hrr_pkg::item_t   item;
    logic             item_valid;
    logic             take;
    logic             fire;
    logic             out_space;
    hrr_pkg::result_t result;
    hrr_pkg::result_t m_result;

    assign s_item.ch   = s_ch;
    assign s_item.last = s_last;

    hrr_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    hrr_core #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .MAX_LINE_CHARS (MAX_LINE_CHARS)
    ) u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_expected_tag (cfg_expected_tag),
        .item_valid       (item_valid),
        .item             (item),
        .out_space        (out_space),
        .take             (take),
        .fire             (fire),
        .result           (result)
    );

    hrr_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (take),
        .fire      (fire),
        .result    (result),
        .out_space (out_space),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

    assign m_is_error   = m_result.is_error;
    assign m_slot       = m_result.slot;
    assign m_reading    = m_result.reading;
    assign m_is_percent = m_result.is_percent;
    assign m_error_code = m_result.error_code;

endmodule
`default_nettype wire
